/* sv/tws_pkg.sv */
// ----------------------------------------------------------------------------
// tws_pkg
// Shared types, codes and default sizes for the triggered waveform summer.
// ----------------------------------------------------------------------------
`default_nettype none

package tws_pkg;

  localparam int DEF_SAMPLE_DEPTH = 4096;
  localparam int DEF_MAX_BINS     = 16;
  localparam int DEF_MAX_SAMPS    = 256;
  localparam int DEF_SAMPLE_BITS  = 16;

  localparam int SUM_W   = 32;
  localparam int CMD_W   = 2;
  localparam int SIDX_W  = 12;
  localparam int SVAL_W  = 16;
  localparam int TTIME_W = 13;
  localparam int BIN_W   = 5;
  localparam int OFF_W   = 8;
  localparam int NSAMP_W = 9;
  localparam int CFG_W   = 9;

  localparam int IN_DATA_W  = 56;
  localparam int OUT_DATA_W = 32;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD    = 2'd0,
    CMD_TRIGGER = 2'd1,
    CMD_READ    = 2'd2,
    CMD_CLEAR   = 2'd3
  } cmd_t;

  localparam logic REG_NUM_BINS    = 1'b0;
  localparam logic REG_NUM_SAMPLES = 1'b1;

endpackage

`default_nettype wire

/* sv/triggered_waveform_summer.sv */
// ----------------------------------------------------------------------------
// triggered_waveform_summer
// Loads samples, sums sample windows into per-bin rows on trigger, reads and
// clears the sum store.
// ----------------------------------------------------------------------------
// Load: accept, then ST_FINISH issues the result; read: ST_READ, ST_FINISH;
// trigger: ST_TRIG, one sum-store read-add-write per offset through a single
// adder; clear: ST_CLEAR, one entry per cycle. One transaction at a time:
// s_tready rises in the same cycle that the result is issued, which waits on
// m_tready. Reset (rst, synchronous): registers go to 16 / 256, then a
// clearing pass zeroes the sum store before s_tready rises.
// ----------------------------------------------------------------------------
`default_nettype none

module triggered_waveform_summer
  import tws_pkg::*;
#(
  parameter int SAMPLE_DEPTH = DEF_SAMPLE_DEPTH,
  parameter int MAX_BINS     = DEF_MAX_BINS,
  parameter int MAX_SAMPS    = DEF_MAX_SAMPS,
  parameter int SAMPLE_BITS  = DEF_SAMPLE_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // sample_index, sample_value, trigger_time, bin_number, offset, zero pad
  input  logic [IN_DATA_W-1:0]  s_tdata,
  // command
  input  logic [CMD_W-1:0]      s_tuser,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // sum_value
  output logic [OUT_DATA_W-1:0] m_tdata,
  // status
  output logic                  m_tuser,
  input  logic                  cfg_wr_en,
  input  logic                  cfg_index,
  input  logic [CFG_W-1:0]      cfg_data
);

  localparam int SUM_DEPTH = MAX_BINS * MAX_SAMPS;
  localparam int SA_W      = $clog2(SAMPLE_DEPTH);
  localparam int SUM_AW    = (SUM_DEPTH > 1) ? $clog2(SUM_DEPTH) : 1;

  typedef enum logic [4:0] {
    ST_CLEAR  = 5'b00001,
    ST_IDLE   = 5'b00010,
    ST_TRIG   = 5'b00100,
    ST_READ   = 5'b01000,
    ST_FINISH = 5'b10000
  } state_t;

  state_t state;

  logic [BIN_W-1:0]   num_bins;
  logic [NSAMP_W-1:0] num_samples;

  logic signed [SAMPLE_BITS-1:0] sample_mem [SAMPLE_DEPTH];
  logic signed [SUM_W-1:0]       sum_mem [SUM_DEPTH];

  // input fields
  cmd_t                cmd;
  logic [SIDX_W-1:0]   sample_index;
  logic signed [SVAL_W-1:0] sample_value;
  logic [TTIME_W-1:0]  trigger_time;
  logic [BIN_W-1:0]    bin_number;
  logic [OFF_W-1:0]    offset;

  assign cmd          = cmd_t'(s_tuser);
  assign sample_index = s_tdata[11:0];
  assign sample_value = s_tdata[27:12];
  assign trigger_time = s_tdata[40:28];
  assign bin_number   = s_tdata[45:41];
  assign offset       = s_tdata[53:46];

  logic accept;
  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;

  // checks
  logic        bin_ok, load_ok, trig_ok, read_ok;
  logic [31:0] row_len, trig_end;
  logic [31:0] row_base32;
  logic signed [31:0] sval32, samp_hi, samp_lo, sval_sat;

  always_comb begin
    bin_ok   = (bin_number != '0) && (32'(bin_number) <= 32'(num_bins)) &&
               (32'(bin_number) <= 32'(MAX_BINS));
    load_ok  = 32'(sample_index) < 32'(SAMPLE_DEPTH);
    trig_end = 32'(trigger_time) - 32'd1 + 32'(num_samples);
    trig_ok  = bin_ok && (trigger_time != '0) && (num_samples != '0) &&
               (32'(num_samples) <= 32'(MAX_SAMPS)) &&
               (trig_end <= 32'(SAMPLE_DEPTH));
    row_len  = (32'(num_samples) > 32'(MAX_SAMPS)) ? 32'(MAX_SAMPS)
                                                   : 32'(num_samples);
    read_ok  = bin_ok && (32'(offset) < row_len);
    row_base32 = (32'(bin_number) - 32'd1) * 32'(MAX_SAMPS);
    sval32   = 32'(sample_value);
    samp_hi  = (32'sd1 <<< (SAMPLE_BITS - 1)) - 32'sd1;
    samp_lo  = -samp_hi - 32'sd1;
    if (sval32 > samp_hi) begin
      sval_sat = samp_hi;
    end else if (sval32 < samp_lo) begin
      sval_sat = samp_lo;
    end else begin
      sval_sat = sval32;
    end
  end

  // sequencer registers
  logic [SUM_AW-1:0]  clr_addr;
  logic               clr_cmd;
  logic [SUM_AW-1:0]  sum_ra;
  logic [SA_W-1:0]    samp_ptr;
  logic [NSAMP_W-1:0] issue_cnt;
  logic               rd_pending;
  logic [SUM_AW-1:0]  wr_addr;
  logic               res_status;
  logic               res_is_read;

  logic signed [SUM_W-1:0]       sum_q;
  logic signed [SAMPLE_BITS-1:0] samp_q;
  logic signed [SUM_W-1:0]       acc_sum;

  tws_sat_add #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_sat_add (
    .acc(sum_q),
    .smp(samp_q),
    .sum(acc_sum)
  );

  // sum store write port
  logic                    sum_we;
  logic [SUM_AW-1:0]       sum_wa;
  logic signed [SUM_W-1:0] sum_wd;

  always_comb begin
    sum_we = 1'b0;
    sum_wa = wr_addr;
    sum_wd = acc_sum;
    if (state == ST_CLEAR) begin
      sum_we = 1'b1;
      sum_wa = clr_addr;
      sum_wd = '0;
    end else if (state == ST_TRIG && rd_pending) begin
      sum_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (sum_we) begin
      sum_mem[sum_wa] <= sum_wd;
    end
    sum_q <= sum_mem[sum_ra];
  end

  always_ff @(posedge clk) begin
    if (accept && cmd == CMD_LOAD && load_ok) begin
      sample_mem[SA_W'(sample_index)] <= SAMPLE_BITS'(sval_sat);
    end
    samp_q <= sample_mem[samp_ptr];
  end

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      num_bins    <= BIN_W'(16);
      num_samples <= NSAMP_W'(256);
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_NUM_BINS:    num_bins    <= cfg_data[BIN_W-1:0];
        REG_NUM_SAMPLES: num_samples <= cfg_data[NSAMP_W-1:0];
        default:         ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      res_is_read <= (cmd == CMD_READ) && read_ok;
      samp_ptr    <= SA_W'(trigger_time - TTIME_W'(1));
      issue_cnt   <= num_samples;
      if (cmd == CMD_READ) begin
        sum_ra <= SUM_AW'(row_base32 + 32'(offset));
      end else begin
        sum_ra <= SUM_AW'(row_base32);
      end
    end else if (state == ST_TRIG && issue_cnt != '0) begin
      sum_ra    <= sum_ra + SUM_AW'(1);
      samp_ptr  <= samp_ptr + SA_W'(1);
      issue_cnt <= issue_cnt - NSAMP_W'(1);
      wr_addr   <= sum_ra;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      clr_addr   <= '0;
      clr_cmd    <= 1'b0;
      rd_pending <= 1'b0;
      res_status <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && state != ST_FINISH) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_CLEAR: begin
          if (32'(clr_addr) == 32'(SUM_DEPTH - 1)) begin
            clr_addr <= '0;
            state    <= clr_cmd ? ST_FINISH : ST_IDLE;
          end else begin
            clr_addr <= clr_addr + SUM_AW'(1);
          end
        end
        ST_IDLE: begin
          if (accept) begin
            case (cmd)
              CMD_LOAD: begin
                res_status <= !load_ok;
                state      <= ST_FINISH;
              end
              CMD_TRIGGER: begin
                res_status <= !trig_ok;
                rd_pending <= 1'b0;
                state      <= trig_ok ? ST_TRIG : ST_FINISH;
              end
              CMD_READ: begin
                res_status <= !read_ok;
                state      <= ST_READ;
              end
              CMD_CLEAR: begin
                res_status <= 1'b0;
                clr_cmd    <= 1'b1;
                clr_addr   <= '0;
                state      <= ST_CLEAR;
              end
              default: state <= ST_FINISH;
            endcase
          end
        end
        ST_TRIG: begin
          rd_pending <= (issue_cnt != '0);
          if (issue_cnt == '0 && !rd_pending) begin
            state <= ST_FINISH;
          end
        end
        ST_READ: begin
          state <= ST_FINISH;
        end
        ST_FINISH: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            clr_cmd  <= 1'b0;
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_FINISH && (!m_tvalid || m_tready)) begin
      m_tdata <= res_is_read ? OUT_DATA_W'(sum_q) : '0;
      m_tuser <= res_status;
    end
  end

endmodule

`default_nettype wire

/* sv/tws_sat_add.sv */
// ----------------------------------------------------------------------------
// tws_sat_add
// Adds a signed sample to a signed 32-bit running sum, clamped to 32 bits.
// ----------------------------------------------------------------------------
`default_nettype none

module tws_sat_add
  import tws_pkg::*;
#(
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
  input  logic signed [SUM_W-1:0]       acc,
  input  logic signed [SAMPLE_BITS-1:0] smp,
  output logic signed [SUM_W-1:0]       sum
);

  logic signed [SUM_W:0] wide;

  always_comb begin
    wide = (SUM_W+1)'(acc) + (SUM_W+1)'(smp);
    if (wide[SUM_W] != wide[SUM_W-1]) begin
      sum = wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
    end else begin
      sum = wide[SUM_W-1:0];
    end
  end

endmodule

`default_nettype wire

/* sim/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the triggered waveform summer. A driver feeds
// load, trigger, read and clear transactions from a queue, an in-bench
// predictor of the sample and sum stores works out each reply on accept, and
// a monitor checks every reply in order. Both stream sides idle at random;
// the register settings change between phases, and a run of triggers on
// full-scale samples builds up large sums of both signs.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tws_pkg::*;

  localparam int SAMPLE_DEPTH   = DEF_SAMPLE_DEPTH;
  localparam int MAX_BINS       = DEF_MAX_BINS;
  localparam int MAX_SAMPS      = DEF_MAX_SAMPS;
  localparam int PHASE_ITEMS    = 110;
  localparam int SAT_BASE       = 100;
  localparam int SAT_TRIGGERS   = 24;
  localparam int SETTLE_CYCLES  = 8;
  localparam int TAIL_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int N_FIXED        = 9;

  localparam longint SUM_HI = 64'sd2147483647;
  localparam longint SUM_LO = -64'sd2147483648;

  typedef struct {
    cmd_t                     cmd;
    logic [SIDX_W-1:0]        sidx;
    logic signed [SVAL_W-1:0] sval;
    logic [TTIME_W-1:0]       ttime;
    logic [BIN_W-1:0]         bin;
    logic [OFF_W-1:0]         off;
  } sum_cmd_t;

  typedef struct {
    logic signed [SUM_W-1:0] sum;
    logic                    status;
  } sum_reply_t;

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  s_tvalid  = 1'b0;
  wire                   s_tready;
  logic [IN_DATA_W-1:0]  s_tdata   = '0;
  logic [CMD_W-1:0]      s_tuser   = CMD_LOAD;
  wire                   m_tvalid;
  logic                  m_tready  = 1'b0;
  wire  [OUT_DATA_W-1:0] m_tdata;
  wire                   m_tuser;
  logic                  cfg_wr_en = 1'b0;
  logic                  cfg_index = REG_NUM_BINS;
  logic [CFG_W-1:0]      cfg_data  = '0;

  // predictor state
  shortint            sample_mem [SAMPLE_DEPTH];
  int                 sum_mem [MAX_BINS*MAX_SAMPS];
  logic [BIN_W-1:0]   bins_reg  = 5'd16;
  logic [NSAMP_W-1:0] samps_reg = 9'd256;

  // stimulus bookkeeping
  bit         loaded [SAMPLE_DEPTH];
  sum_cmd_t   pending_items [$];
  sum_reply_t sums_due [$];
  sum_cmd_t   in_flight;
  sum_reply_t want_reply;
  int         item_count   = 0;
  int         fail_count   = 0;
  int         send_gap     = 0;
  int         recv_stall   = 0;
  int         quiet_cycles = 0;
  bit         idle_en      = 1'b1;

  int fixed_bins  [N_FIXED] = '{16, 16, 1, 0, 31, 16, 5, 12, 8};
  int fixed_samps [N_FIXED] = '{1, 256, 256, 0, 511, 257, 8, 3, 16};

  triggered_waveform_summer dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor
  function automatic bit bin_in_use(logic [BIN_W-1:0] b);
    return b >= 1 && b <= bins_reg && b <= MAX_BINS;
  endfunction

  function automatic bit trigger_rejected(logic [TTIME_W-1:0] t, logic [BIN_W-1:0] b);
    return !bin_in_use(b) || t == 0 || samps_reg == 0 || samps_reg > MAX_SAMPS ||
           int'(t) - 1 + int'(samps_reg) > SAMPLE_DEPTH;
  endfunction

  function automatic void predict_reply(sum_cmd_t c);
    sum_reply_t r;
    int         base;
    int         row;
    longint     acc;
    r.sum    = '0;
    r.status = 1'b0;
    case (c.cmd)
      CMD_LOAD: begin
        sample_mem[c.sidx] = c.sval;
      end
      CMD_TRIGGER: begin
        if (trigger_rejected(c.ttime, c.bin)) begin
          r.status = 1'b1;
        end else begin
          base = (int'(c.bin) - 1) * MAX_SAMPS;
          for (int j = 0; j < int'(samps_reg); j++) begin
            acc = longint'(sum_mem[base + j]) + longint'(sample_mem[int'(c.ttime) - 1 + j]);
            if (acc > SUM_HI) acc = SUM_HI;
            if (acc < SUM_LO) acc = SUM_LO;
            sum_mem[base + j] = int'(acc);
          end
        end
      end
      CMD_READ: begin
        row = (samps_reg > MAX_SAMPS) ? MAX_SAMPS : int'(samps_reg);
        if (!bin_in_use(c.bin) || int'(c.off) >= row) begin
          r.status = 1'b1;
        end else begin
          r.sum = sum_mem[(int'(c.bin) - 1) * MAX_SAMPS + int'(c.off)];
        end
      end
      CMD_CLEAR: begin
        foreach (sum_mem[k]) sum_mem[k] = 0;
      end
      default: ;
    endcase
    sums_due.push_back(r);
  endfunction

  // ---------------------------------------------------------------- stimulus
  function automatic int pick_gap();
    int r;
    if (!idle_en) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic signed [SVAL_W-1:0] rand_sample();
    case ($urandom_range(0, 9))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2: return SVAL_W'(int'($urandom_range(0, 32)) - 16);
      default: return SVAL_W'($urandom);
    endcase
  endfunction

  function automatic sum_cmd_t rand_cmd(cmd_t k);
    sum_cmd_t c;
    c.cmd   = k;
    c.sidx  = SIDX_W'($urandom);
    c.sval  = SVAL_W'($urandom);
    c.ttime = TTIME_W'($urandom);
    c.bin   = BIN_W'($urandom);
    c.off   = OFF_W'($urandom);
    return c;
  endfunction

  task automatic push_item(sum_cmd_t c);
    pending_items.push_back(c);
    item_count++;
  endtask

  task automatic push_load(int idx, logic signed [SVAL_W-1:0] v);
    sum_cmd_t c;
    c      = rand_cmd(CMD_LOAD);
    c.sidx = SIDX_W'(idx);
    c.sval = v;
    loaded[idx] = 1'b1;
    push_item(c);
  endtask

  task automatic push_read(int b, int o);
    sum_cmd_t c;
    c     = rand_cmd(CMD_READ);
    c.bin = BIN_W'(b);
    c.off = OFF_W'(o);
    push_item(c);
  endtask

  // A trigger that would be taken must only cover loaded samples: fill the
  // gaps first, or spoil the bin if the gap is larger than allowed.
  task automatic push_trigger(sum_cmd_t c, int fill_limit);
    int missing;
    missing = 0;
    if (!trigger_rejected(c.ttime, c.bin)) begin
      for (int j = 0; j < int'(samps_reg); j++)
        if (!loaded[int'(c.ttime) - 1 + j]) missing++;
      if (missing > fill_limit) begin
        c.bin = '0;
      end else begin
        for (int j = 0; j < int'(samps_reg); j++)
          if (!loaded[int'(c.ttime) - 1 + j]) push_load(int'(c.ttime) - 1 + j, rand_sample());
      end
    end
    push_item(c);
  endtask

  task automatic push_trig_at(int t, int b);
    sum_cmd_t c;
    c       = rand_cmd(CMD_TRIGGER);
    c.ttime = TTIME_W'(t);
    c.bin   = BIN_W'(b);
    push_trigger(c, 0);
  endtask

  task automatic well_formed_burst();
    int       ns;
    int       row;
    int       last_t0;
    int       t0;
    int       bin_hi;
    int       reps;
    sum_cmd_t c;
    ns = (samps_reg >= 1 && samps_reg <= MAX_SAMPS) ? int'(samps_reg) : $urandom_range(1, 16);
    last_t0 = SAMPLE_DEPTH - ns + 1;
    case ($urandom_range(0, 9))
      0: t0 = 1;
      1: t0 = last_t0;
      default: t0 = (ns > 32) ? $urandom_range(1, 300) : $urandom_range(1, last_t0);
    endcase
    bin_hi = (bins_reg == 0) ? 1 : ((bins_reg > MAX_BINS) ? MAX_BINS : int'(bins_reg));
    reps = $urandom_range(0, 3);
    repeat (reps) push_load(t0 - 1 + $urandom_range(0, ns - 1), rand_sample());
    reps = $urandom_range(1, 3);
    repeat (reps) begin
      c       = rand_cmd(CMD_TRIGGER);
      c.ttime = TTIME_W'(t0);
      c.bin   = BIN_W'($urandom_range(1, bin_hi));
      push_trigger(c, MAX_SAMPS);
    end
    row = (samps_reg > MAX_SAMPS) ? MAX_SAMPS : int'(samps_reg);
    reps = $urandom_range(1, 4);
    repeat (reps)
      push_read($urandom_range(1, bin_hi), (row > 0) ? $urandom_range(0, row - 1) : $urandom);
  endtask

  task automatic random_phase(int n);
    int stop_at;
    int r;
    stop_at = item_count + n;
    while (item_count < stop_at) begin
      r = $urandom_range(0, 199);
      if (r < 90) well_formed_burst();
      else if (r < 120) push_trigger(rand_cmd(CMD_TRIGGER), 0);
      else if (r < 160) push_item(rand_cmd(CMD_READ));
      else if (r < 198) push_load($urandom_range(0, SAMPLE_DEPTH - 1), rand_sample());
      else push_item(rand_cmd(CMD_CLEAR));
    end
  endtask

  task automatic wait_idle();
    @(negedge clk);
    while (pending_items.size() != 0 || s_tvalid || sums_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_cfg(logic idx, logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    if (idx == REG_NUM_BINS) bins_reg = val[BIN_W-1:0];
    else samps_reg = val[NSAMP_W-1:0];
  endtask

  // upper data bits of the bin count are junk and must be dropped
  task automatic set_config(int b, int ns);
    logic [CFG_W-1:0] v;
    wait_idle();
    v = CFG_W'($urandom);
    v[BIN_W-1:0] = BIN_W'(b);
    write_cfg(REG_NUM_BINS, v);
    write_cfg(REG_NUM_SAMPLES, CFG_W'(ns));
  endtask

  task automatic saturation_phase();
    set_config(1, 2);
    idle_en = 1'b0;
    push_item(rand_cmd(CMD_CLEAR));
    push_load(SAT_BASE, 16'sh7FFF);
    push_load(SAT_BASE + 1, 16'sh8000);
    for (int i = 0; i < SAT_TRIGGERS; i++) begin
      push_trig_at(SAT_BASE + 1, 1);
      if (i % 8 == 0) begin
        push_read(1, 0);
        push_read(1, 1);
      end
    end
    push_read(1, 0);
    push_read(1, 1);
    push_item(rand_cmd(CMD_CLEAR));
    push_read(1, 0);
  endtask

  // ---------------------------------------------------------------- driver
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) predict_reply(in_flight);
      if (!s_tvalid || s_tready) begin
        if (send_gap > 0) begin
          send_gap--;
          s_tvalid <= 1'b0;
        end else if (pending_items.size() != 0) begin
          in_flight = pending_items.pop_front();
          s_tdata  <= {2'b00, in_flight.off, in_flight.bin, in_flight.ttime,
                       in_flight.sval, in_flight.sidx};
          s_tuser  <= in_flight.cmd;
          s_tvalid <= 1'b1;
          send_gap = pick_gap();
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------- monitor
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (sums_due.size() == 0) begin
          $error("unexpected transaction: sum_value %0d status %0d", $signed(m_tdata), m_tuser);
          fail_count++;
        end else begin
          want_reply = sums_due.pop_front();
          if (m_tdata !== want_reply.sum) begin
            $error("sum_value: expected %0d, got %0d", want_reply.sum, $signed(m_tdata));
            fail_count++;
          end
          if (m_tuser !== want_reply.status) begin
            $error("status: expected %0d, got %0d", want_reply.status, m_tuser);
            fail_count++;
          end
        end
      end
      if (recv_stall > 0) begin
        recv_stall--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
        recv_stall = pick_gap();
      end
    end
  end

  // ---------------------------------------------------------------- watchdog
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------- sequence
  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // reset settings: 16 bins, 256 samples
    push_load(0, 16'sh7FFF);
    push_load(SAMPLE_DEPTH - 1, 16'sh8000);
    push_load(SAMPLE_DEPTH / 2 - 1, 16'shFFFF);
    push_read(1, 0);
    push_read(16, 255);
    push_read(0, 0);
    push_read(17, 3);
    push_read(31, 255);
    push_trig_at(0, 1);
    push_trig_at(SAMPLE_DEPTH - MAX_SAMPS + 2, 1);  // window runs past the store
    push_trig_at(8191, 16);
    push_trig_at(1, 17);
    push_trig_at(1, 0);
    push_item(rand_cmd(CMD_CLEAR));
    push_read(16, 0);
    random_phase(PHASE_ITEMS);

    // single bin, single sample: both ends of the sample store
    set_config(1, 1);
    push_trig_at(1, 1);
    push_trig_at(SAMPLE_DEPTH, 1);
    push_read(1, 0);
    push_read(1, 1);
    push_read(2, 0);
    push_trig_at(1, 2);
    push_trig_at(SAMPLE_DEPTH + 1, 1);
    random_phase(PHASE_ITEMS);

    for (int p = 0; p < N_FIXED; p++) begin
      set_config(fixed_bins[p], fixed_samps[p]);
      idle_en = ($urandom_range(0, 3) != 0);
      random_phase(PHASE_ITEMS);
    end

    repeat (4) begin
      case ($urandom_range(0, 9))
        0, 1: set_config($urandom_range(1, 16), $urandom_range(17, 64));
        2:    set_config($urandom_range(1, 16), $urandom_range(200, 256));
        default: set_config($urandom_range(1, 16), $urandom_range(1, 16));
      endcase
      idle_en = ($urandom_range(0, 3) != 0);
      random_phase(PHASE_ITEMS);
    end

    saturation_phase();

    wait_idle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule

/* files.f */
sv/tws_pkg.sv
sv/tws_sat_add.sv
sv/triggered_waveform_summer.sv
sim/tb.sv
